FILE: rtl/tcs_pkg.sv
// Text console scrollback: shared types, codes and character cleanup.
// Used by tcs_core and text_console_scrollback; depends on nothing else.
package tcs_pkg;

    // Operation codes carried in the item's operation field
    localparam logic [2:0] OP_PUT       = 3'd0;
    localparam logic [2:0] OP_PAGE_UP   = 3'd1;
    localparam logic [2:0] OP_PAGE_DOWN = 3'd2;
    localparam logic [2:0] OP_FOLLOW    = 3'd3;
    localparam logic [2:0] OP_READ_CELL = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEXT_COLUMNS   = 2'd0;
    localparam logic [1:0] CFG_TEXT_ROWS      = 2'd1;
    localparam logic [1:0] CFG_DISPLAY_ENABLE = 2'd2;

    localparam logic [8:0] COLUMNS_RESET = 9'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd25;
    localparam logic       ENABLE_RESET  = 1'b1;

    // Control characters and fixed glyphs
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [6:0] CH_SPACE    = 7'h20;
    localparam logic [6:0] CH_QUESTION = 7'h3F;

    typedef struct packed {
        logic [8:0] text_columns;
        logic [7:0] text_rows;
        logic       display_enable;
    } cfg_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] character;
        logic [7:0] screen_row;
        logic [7:0] screen_col;
    } item_t;

    typedef struct packed {
        logic       draw_valid;
        logic [7:0] draw_row;
        logic [7:0] draw_col;
        logic [6:0] draw_char;
        logic       redraw;
        logic [6:0] cell_char;
        logic [8:0] view_top;
        logic [9:0] line_count;
        logic       viewing_history;
    } result_t;

    // Fold to upper case, tab to space, anything outside the glyph set to '?'
    function automatic logic [6:0] clean_char(input logic [7:0] raw);
        logic [7:0] u;
        logic       keep;
        u = raw;
        if (raw >= CH_LOWER_A && raw <= CH_LOWER_Z)
            u = raw - CASE_OFFSET;
        // space ! ' ( ) , - . / : = ? _ digits and capitals
        keep = (u == 8'h20) || (u == 8'h21) || (u == 8'h27) || (u == 8'h28) ||
               (u == 8'h29) || (u == 8'h2C) || (u == 8'h2D) || (u == 8'h2E) ||
               (u == 8'h2F) || (u == 8'h3A) || (u == 8'h3D) || (u == 8'h3F) ||
               (u == 8'h5F) || (u >= 8'h30 && u <= 8'h39) ||
               (u >= 8'h41 && u <= 8'h5A);
        if (raw == CH_TAB)
            clean_char = CH_SPACE;
        else if (keep)
            clean_char = u[6:0];
        else
            clean_char = CH_QUESTION;
    endfunction

endpackage

FILE: rtl/tcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; instantiated by tcs_core for the line store and line lengths.
module tcs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

FILE: rtl/tcs_core.sv
// Console state, per-item update logic, line store and length RAMs, result register.
// Depends on tcs_pkg and tcs_ram.
module tcs_core #(
    parameter int unsigned RING_LINES = 512,
    parameter int unsigned LINE_CHARS = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  tcs_pkg::cfg_t    cfg,
    input  tcs_pkg::item_t   item,
    output tcs_pkg::result_t result
);

    localparam int unsigned LW  = $clog2(RING_LINES);
    localparam int unsigned VW  = $clog2(RING_LINES + 1);
    localparam int unsigned CW  = $clog2(LINE_CHARS + 1);
    localparam int unsigned SW  = $clog2(RING_LINES * LINE_CHARS);
    localparam int unsigned MW0 = (VW > CW) ? VW : CW;
    localparam int unsigned NW  = ((MW0 > 10) ? MW0 : 10) + 1;

    typedef struct packed {
        logic [LW-1:0] oldest;
        logic [VW-1:0] vlines;
        logic [LW-1:0] wline;
        logic [CW-1:0] wcol;
        logic [LW-1:0] vtop;
        logic [7:0]    crow;
        logic [8:0]    ccol;
        logic [CW-1:0] cur_len;
    } st_t;

    typedef struct packed {
        st_t  s;
        logic redraw;
    } nl_t;

    function automatic logic [LW-1:0] inc_line(input logic [LW-1:0] x);
        if (x == LW'(RING_LINES - 1))
            inc_line = '0;
        else
            inc_line = x + LW'(1);
    endfunction

    function automatic logic [LW-1:0] tail_of(input st_t s, input logic [7:0] rows);
        logic [NW-1:0] t;
        t = '0;
        if (rows != 8'd0 && NW'(s.vlines) > NW'(rows))
            t = NW'(s.vlines) - NW'(rows);
        tail_of = t[LW-1:0];
    endfunction

    function automatic logic [7:0] last_row(input logic [7:0] rows);
        last_row = (rows != 8'd0) ? rows - 8'd1 : 8'd0;
    endfunction

    // Put the cursor back on the newest line when the view sits at the tail
    function automatic st_t repaint(input st_t s_in, input tcs_pkg::cfg_t c,
                                    input logic [NW-1:0] cols);
        st_t           s;
        logic [NW-1:0] row;
        s = s_in;
        if (c.text_rows != 8'd0 && cols != '0 && s.vtop == tail_of(s, c.text_rows))
        begin
            row = NW'(s.vlines) - NW'(1) - NW'(s.vtop);
            s.crow = (row < NW'(c.text_rows)) ? row[7:0] : c.text_rows - 8'd1;
            s.ccol = (NW'(s.wcol) < cols) ? 9'(s.wcol) : 9'd0;
        end
        repaint = s;
    endfunction

    function automatic nl_t new_line(input st_t s_in, input tcs_pkg::cfg_t c);
        st_t           s;
        nl_t           r;
        logic          was_tail;
        logic [LW-1:0] tl;
        logic [8:0]    row_inc;
        s = s_in;
        r.redraw = 1'b0;
        was_tail = (s.vtop == tail_of(s, c.text_rows));
        if (s.vlines < VW'(RING_LINES))
            s.vlines = s.vlines + VW'(1);
        else
        begin
            // ring full: drop the oldest line, keep a pinned view on the same text
            s.oldest = inc_line(s.oldest);
            if (!was_tail && s.vtop != '0)
                s.vtop = s.vtop - LW'(1);
        end
        s.wline   = inc_line(s.wline);
        s.cur_len = '0;
        s.wcol    = '0;
        tl = tail_of(s, c.text_rows);
        if (was_tail)
            s.vtop = tl;
        if (s.vtop > tl)
            s.vtop = tl;
        if (c.display_enable && s.vtop == tl)
        begin
            s.ccol  = '0;
            row_inc = {1'b0, s.crow} + 9'd1;
            if (row_inc >= {1'b0, c.text_rows})
            begin
                r.redraw = 1'b1;
                s.crow   = last_row(c.text_rows);
            end
            else
                s.crow = row_inc[7:0];
        end
        r.s = s;
        new_line = r;
    endfunction

    st_t              st_reg, st_next;
    tcs_pkg::result_t res_reg, res_next;
    logic             rd_ok_reg, rd_ok_next;
    logic             rd_cur_reg, rd_cur_next;
    logic [CW-1:0]    len_snap_reg, len_snap_next;
    logic [7:0]       scol_reg, scol_next;

    logic             st_we;
    logic [LW-1:0]    st_wline;
    logic [CW-1:0]    st_wcol;
    logic [6:0]       st_wdata;
    logic             len_we;
    logic [LW-1:0]    len_waddr;
    logic [CW-1:0]    len_wdata;
    logic             rd_en;
    logic [LW-1:0]    rd_line;
    logic [SW-1:0]    st_waddr, st_raddr;
    logic [6:0]       store_q;
    logic [CW-1:0]    len_q;
    logic [CW-1:0]    len_sel;

    always_comb
    begin
        st_t           s;
        nl_t           nl;
        logic [NW-1:0] cols;
        logic [7:0]    rows;
        logic [7:0]    pstep;
        logic [LW-1:0] tl;
        logic [NW-1:0] sum;
        logic [NW-1:0] logical;
        logic [6:0]    ch_clean;

        s     = st_reg;
        nl    = '0;
        rows  = cfg.text_rows;
        cols  = (NW'(cfg.text_columns) > NW'(LINE_CHARS)) ? NW'(LINE_CHARS)
                                                            : NW'(cfg.text_columns);
        pstep = (rows > 8'd1) ? rows - 8'd1 : 8'd1;

        res_next      = '0;
        rd_ok_next    = 1'b0;
        rd_cur_next   = 1'b0;
        len_snap_next = s.cur_len;
        scol_next     = item.screen_col;
        st_we         = 1'b0;
        st_wline      = s.wline;
        st_wcol       = s.wcol;
        st_wdata      = tcs_pkg::CH_SPACE;
        len_we        = 1'b0;
        len_waddr     = s.wline;
        len_wdata     = s.cur_len;
        rd_en         = 1'b0;
        rd_line       = '0;
        tl            = '0;
        sum           = '0;
        logical       = '0;
        ch_clean      = tcs_pkg::clean_char(item.character);

        case (item.operation)
            tcs_pkg::OP_PUT:
            begin
                if (item.character == tcs_pkg::CH_CR)
                begin
                    s.wcol = '0;
                    if (cfg.display_enable && s.vtop == tail_of(s, rows))
                        s.ccol = '0;
                end
                else if (item.character == tcs_pkg::CH_LF)
                begin
                    // retire the current line's length into the RAM
                    len_we    = 1'b1;
                    len_waddr = s.wline;
                    len_wdata = s.cur_len;
                    nl = new_line(s, cfg);
                    s  = nl.s;
                    res_next.redraw = nl.redraw;
                end
                else if (item.character == tcs_pkg::CH_BS)
                begin
                    if (s.wcol != '0)
                    begin
                        s.wcol = s.wcol - CW'(1);
                        if (NW'(s.wcol) < NW'(LINE_CHARS))
                        begin
                            st_we    = 1'b1;
                            st_wline = s.wline;
                            st_wcol  = s.wcol;
                            st_wdata = tcs_pkg::CH_SPACE;
                        end
                        if (s.cur_len > s.wcol)
                            s.cur_len = s.wcol;
                        if (cfg.display_enable && s.vtop == tail_of(s, rows))
                        begin
                            if (s.ccol != 9'd0)
                                s.ccol = s.ccol - 9'd1;
                            res_next.draw_valid = 1'b1;
                            res_next.draw_row   = s.crow;
                            res_next.draw_col   = s.ccol[7:0];
                            res_next.draw_char  = tcs_pkg::CH_SPACE;
                        end
                    end
                end
                else if (cols != '0)
                begin
                    // full line: wrap before storing
                    if (NW'(s.wcol) >= cols)
                    begin
                        len_we    = 1'b1;
                        len_waddr = s.wline;
                        len_wdata = s.cur_len;
                        nl = new_line(s, cfg);
                        s  = nl.s;
                        res_next.redraw = nl.redraw;
                    end
                    if (NW'(s.wcol) < NW'(LINE_CHARS))
                    begin
                        st_we    = 1'b1;
                        st_wline = s.wline;
                        st_wcol  = s.wcol;
                        st_wdata = ch_clean;
                        if (NW'(s.wcol) + NW'(1) > NW'(s.cur_len))
                            s.cur_len = s.wcol + CW'(1);
                    end
                    s.wcol = s.wcol + CW'(1);
                    if (cfg.display_enable && s.vtop == tail_of(s, rows))
                    begin
                        // cursor past the last column: only reachable without a wrap above
                        if (NW'(s.ccol) + NW'(1) > cols)
                        begin
                            len_we    = 1'b1;
                            len_waddr = s.wline;
                            len_wdata = s.cur_len;
                            nl = new_line(s, cfg);
                            s  = nl.s;
                            res_next.redraw = nl.redraw;
                        end
                        if (s.crow >= rows)
                        begin
                            res_next.redraw = 1'b1;
                            s.ccol = '0;
                            s.crow = last_row(rows);
                        end
                        res_next.draw_valid = 1'b1;
                        res_next.draw_row   = s.crow;
                        res_next.draw_col   = s.ccol[7:0];
                        res_next.draw_char  = ch_clean;
                        s.ccol = s.ccol + 9'd1;
                    end
                end
            end
            tcs_pkg::OP_PAGE_UP:
            begin
                if (cfg.display_enable && rows != 8'd0)
                begin
                    if (NW'(s.vtop) > NW'(pstep))
                        s.vtop = LW'(NW'(s.vtop) - NW'(pstep));
                    else
                        s.vtop = '0;
                    s = repaint(s, cfg, cols);
                    res_next.redraw = 1'b1;
                end
            end
            tcs_pkg::OP_PAGE_DOWN:
            begin
                if (cfg.display_enable && rows != 8'd0)
                begin
                    tl  = tail_of(s, rows);
                    sum = NW'(s.vtop) + NW'(pstep);
                    s.vtop = (sum < NW'(tl)) ? LW'(sum) : tl;
                    s = repaint(s, cfg, cols);
                    res_next.redraw = 1'b1;
                end
            end
            tcs_pkg::OP_FOLLOW:
            begin
                if (cfg.display_enable)
                begin
                    s.vtop = tail_of(s, rows);
                    s = repaint(s, cfg, cols);
                    res_next.redraw = 1'b1;
                end
            end
            tcs_pkg::OP_READ_CELL:
            begin
                res_next.cell_char = tcs_pkg::CH_SPACE;
                logical = NW'(s.vtop) + NW'(item.screen_row);
                rd_ok_next = (item.screen_row < rows) && (NW'(item.screen_col) < cols) &&
                             (logical < NW'(s.vlines));
                // logical is below the line count, so one subtract wraps the ring
                sum = NW'(s.oldest) + logical;
                if (sum >= NW'(RING_LINES))
                    rd_line = LW'(sum - NW'(RING_LINES));
                else
                    rd_line = LW'(sum);
                rd_en       = rd_ok_next;
                rd_cur_next = (rd_line == s.wline);
            end
            default:
            begin
            end
        endcase

        res_next.view_top        = 9'(s.vtop);
        res_next.line_count      = 10'(s.vlines);
        res_next.viewing_history = (s.vtop != tail_of(s, rows));
        st_next = s;
    end

    assign st_waddr = SW'(st_wline) * SW'(LINE_CHARS) + SW'(st_wcol);
    assign st_raddr = SW'(rd_line) * SW'(LINE_CHARS) + SW'(item.screen_col);

    tcs_ram #(
        .WIDTH(7),
        .DEPTH(RING_LINES * LINE_CHARS)
    ) u_store (
        .clk  (clk),
        .we   (step && st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .re   (step && rd_en),
        .raddr(st_raddr),
        .rdata(store_q)
    );

    // Holds lengths of retired lines; the line being written lives in cur_len
    tcs_ram #(
        .WIDTH(CW),
        .DEPTH(RING_LINES)
    ) u_lengths (
        .clk  (clk),
        .we   (step && len_we),
        .waddr(len_waddr),
        .wdata(len_wdata),
        .re   (step && rd_en),
        .raddr(rd_line),
        .rdata(len_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.oldest  <= '0;
            st_reg.vlines  <= VW'(1);
            st_reg.wline   <= '0;
            st_reg.wcol    <= '0;
            st_reg.vtop    <= '0;
            st_reg.crow    <= '0;
            st_reg.ccol    <= '0;
            st_reg.cur_len <= '0;
            rd_ok_reg      <= 1'b0;
        end
        else if (step)
        begin
            st_reg    <= st_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg      <= res_next;
            rd_cur_reg   <= rd_cur_next;
            len_snap_reg <= len_snap_next;
            scol_reg     <= scol_next;
        end
    end

    assign len_sel = rd_cur_reg ? len_snap_reg : len_q;

    always_comb
    begin
        result = res_reg;
        if (rd_ok_reg && NW'(scol_reg) < NW'(len_sel))
            result.cell_char = store_q;
    end

`ifndef SYNTHESIS
    a_line_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.vlines != '0 && st_reg.vlines <= VW'(RING_LINES))
        else $error("line count out of range");

    a_oldest_until_full : assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.vlines < VW'(RING_LINES) |-> st_reg.oldest == '0)
        else $error("oldest line moved before the ring filled");

    a_write_line_is_newest : assert property (@(posedge clk) disable iff (!rst_n)
        (NW'(st_reg.oldest) + NW'(st_reg.vlines) - NW'(1)) == NW'(st_reg.wline) ||
        (NW'(st_reg.oldest) + NW'(st_reg.vlines) - NW'(1)) ==
            NW'(st_reg.wline) + NW'(RING_LINES))
        else $error("write line is not the newest line of the ring");

    a_column_bounds : assert property (@(posedge clk) disable iff (!rst_n)
        NW'(st_reg.wcol) <= NW'(LINE_CHARS) && NW'(st_reg.cur_len) <= NW'(LINE_CHARS))
        else $error("write column or line length past the line size");

    a_read_no_write : assert property (@(posedge clk) disable iff (!rst_n)
        step && item.operation == tcs_pkg::OP_READ_CELL |-> !st_we && !len_we)
        else $error("cell read wrote a store");
`endif

endmodule

FILE: rtl/text_console_scrollback.sv
// Top level of the text console scrollback: configuration registers and handshake stages.
// Depends on tcs_pkg and tcs_core (which uses tcs_ram).

// Text console with a ring of RING_LINES scrollback lines of LINE_CHARS cells each.
// Items (put character, page up, page down, follow tail, read cell) are taken one
// per clock unless stalled, and every item yields exactly one result transaction.
// Each item passes an input register, then one pass of update logic that also issues
// the line store and line length RAM reads into the result register. The single
// write port of each RAM bounds the work to one store write and one length write per
// item, which a single item never exceeds. No clearing pass runs after reset: the
// line being written keeps its length in a register and other lines' lengths are
// stored when they are left, so the block takes items from the first cycle after reset.
// Configuration writes are always ready and must only be issued while idle.
module text_console_scrollback #(
    parameter int unsigned RING_LINES = 512,
    parameter int unsigned LINE_CHARS = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  tcs_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output tcs_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [8:0]       cfg_data
);

    tcs_pkg::cfg_t  cfg_reg;
    tcs_pkg::item_t item_reg;
    logic           in_full_reg, in_full_next;
    logic           out_full_reg, out_full_next;
    logic           step;
    logic           accept;

    assign cfg_ready = 1'b1;

    // Advance the held item when the result stage is empty or draining
    assign step         = in_full_reg && (!out_full_reg || !result_stall);
    assign item_stall   = in_full_reg && !step;
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_full_reg;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
            in_full_next = 1'b1;
        else if (step)
            in_full_next = 1'b0;

        out_full_next = out_full_reg;
        if (step)
            out_full_next = 1'b1;
        else if (out_full_reg && !result_stall)
            out_full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_columns   <= tcs_pkg::COLUMNS_RESET;
            cfg_reg.text_rows      <= tcs_pkg::ROWS_RESET;
            cfg_reg.display_enable <= tcs_pkg::ENABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcs_pkg::CFG_TEXT_COLUMNS:   cfg_reg.text_columns   <= cfg_data;
                tcs_pkg::CFG_TEXT_ROWS:      cfg_reg.text_rows      <= cfg_data[7:0];
                tcs_pkg::CFG_DISPLAY_ENABLE: cfg_reg.display_enable <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    tcs_core #(
        .RING_LINES(RING_LINES),
        .LINE_CHARS(LINE_CHARS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cfg   (cfg_reg),
        .item  (item_reg),
        .result(result)
    );

endmodule
